// File: hw/rtl/sha1_pkg.sv
// Shared constants, types and helper functions for the SHA-1 stream hash.
// No dependencies; the engine, the top level and the bench import this package.
package sha1_pkg;

   localparam int BLOCK_BYTES  = 64;
   localparam int FILL_W       = $clog2(BLOCK_BYTES);
   localparam int LEN_FILL     = BLOCK_BYTES - 8;
   localparam int BLOCK_BITS   = BLOCK_BYTES * 8;
   localparam int ROUNDS       = 80;
   localparam int ROUND_W      = $clog2(ROUNDS);
   localparam int DIGEST_WORDS = 5;
   localparam int IDX_W        = 3;

   localparam logic [31:0] H_INIT0 = 32'h67452301;
   localparam logic [31:0] H_INIT1 = 32'hefcdab89;
   localparam logic [31:0] H_INIT2 = 32'h98badcfe;
   localparam logic [31:0] H_INIT3 = 32'h10325476;
   localparam logic [31:0] H_INIT4 = 32'hc3d2e1f0;

   localparam logic [31:0] K_ROUND0 = 32'h5a827999;
   localparam logic [31:0] K_ROUND1 = 32'h6ed9eba1;
   localparam logic [31:0] K_ROUND2 = 32'h8f1bbcdc;
   localparam logic [31:0] K_ROUND3 = 32'hca62c1d6;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } state_type;

   // commands from the sequencer to the compression engine
   typedef struct packed {
      logic       init;
      logic       shift_byte;
      logic [7:0] byte_val;
      logic       load;
      logic       round;
      logic       add;
      logic       rotate;
   } eng_ctrl_type;

   typedef struct packed {
      logic        round_last;
      logic [31:0] h0;
   } eng_stat_type;

   function automatic logic [31:0] rol1(input logic [31:0] v);
      return {v[30:0], v[31]};
   endfunction

   function automatic logic [31:0] rol5(input logic [31:0] v);
      return {v[26:0], v[31:27]};
   endfunction

   function automatic logic [31:0] rol30(input logic [31:0] v);
      return {v[1:0], v[31:2]};
   endfunction

endpackage

// File: hw/rtl/sha1_if.sv
// Handshake channels of the SHA-1 stream hash: request and digest response.
// Depends on nothing; used by the top level and its environment.
interface sha1_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] msg_byte;

   modport source (output valid, kind, msg_byte, input ready);
   modport sink   (input valid, kind, msg_byte, output ready);
endinterface

interface sha1_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: hw/rtl/sha1_engine.sv
// SHA-1 compression engine: chain words, working variables, rolling schedule.
// One round per cycle through a single shared round unit. Uses sha1_pkg.
module sha1_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  sha1_pkg::eng_ctrl_type ctrl,
   output sha1_pkg::eng_stat_type stat
);
   import sha1_pkg::*;

   logic [31:0] h0_ff, h1_ff, h2_ff, h3_ff, h4_ff;
   logic [31:0] h0_in, h1_in, h2_in, h3_in, h4_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [ROUND_W-1:0] cnt_ff, cnt_in;
   logic [BLOCK_BITS-1:0] win_ff, win_in;

   logic [31:0] w0, w2, w8, w13, w_next;
   logic [31:0] f_val, k_val, t_val;

   // window word i sits at the top for i = 0, oldest first
   assign w0  = win_ff[BLOCK_BITS-1    -: 32];
   assign w2  = win_ff[BLOCK_BITS-1-64  -: 32];
   assign w8  = win_ff[BLOCK_BITS-1-256 -: 32];
   assign w13 = win_ff[BLOCK_BITS-1-416 -: 32];
   assign w_next = rol1(w13 ^ w8 ^ w2 ^ w0);

   always_comb begin
      if (cnt_ff < ROUND_W'(20)) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K_ROUND0;
      end else if (cnt_ff < ROUND_W'(40)) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_ROUND1;
      end else if (cnt_ff < ROUND_W'(60)) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K_ROUND2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_ROUND3;
      end
      t_val = rol5(a_ff) + f_val + e_ff + k_val + w0;
   end

   always_comb begin
      h0_in = h0_ff; h1_in = h1_ff; h2_in = h2_ff; h3_in = h3_ff; h4_in = h4_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      cnt_in = cnt_ff;
      win_in = win_ff;
      if (ctrl.init) begin
         h0_in = H_INIT0; h1_in = H_INIT1; h2_in = H_INIT2;
         h3_in = H_INIT3; h4_in = H_INIT4;
      end else if (ctrl.add) begin
         h0_in = h0_ff + a_ff; h1_in = h1_ff + b_ff; h2_in = h2_ff + c_ff;
         h3_in = h3_ff + d_ff; h4_in = h4_ff + e_ff;
      end else if (ctrl.rotate) begin
         h0_in = h1_ff; h1_in = h2_ff; h2_in = h3_ff; h3_in = h4_ff; h4_in = h0_ff;
      end
      if (ctrl.shift_byte) begin
         win_in = {win_ff[BLOCK_BITS-9:0], ctrl.byte_val};
      end else if (ctrl.round) begin
         win_in = {win_ff[BLOCK_BITS-33:0], w_next};
      end
      if (ctrl.load) begin
         a_in = h0_ff; b_in = h1_ff; c_in = h2_ff; d_in = h3_ff; e_in = h4_ff;
         cnt_in = '0;
      end else if (ctrl.round) begin
         a_in = t_val;
         b_in = a_ff;
         c_in = rol30(b_ff);
         d_in = c_ff;
         e_in = d_ff;
         cnt_in = (cnt_ff == ROUND_W'(ROUNDS - 1)) ? '0 : cnt_ff + ROUND_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h0_ff  <= H_INIT0;
         h1_ff  <= H_INIT1;
         h2_ff  <= H_INIT2;
         h3_ff  <= H_INIT3;
         h4_ff  <= H_INIT4;
         cnt_ff <= '0;
      end else begin
         h0_ff  <= h0_in;
         h1_ff  <= h1_in;
         h2_ff  <= h2_in;
         h3_ff  <= h3_in;
         h4_ff  <= h4_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
      win_ff <= win_in;
   end

   assign stat.round_last = ctrl.round && (cnt_ff == ROUND_W'(ROUNDS - 1));
   assign stat.h0         = h0_ff;

`ifndef SYNTHESIS
   a_no_mix: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.round && (ctrl.shift_byte || ctrl.load || ctrl.add)))
      else $error("round issued together with a buffer or chain command");
   a_load_cnt: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |=> cnt_ff == '0)
      else $error("round counter not cleared by load");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= ROUND_W'(ROUNDS - 1))
      else $error("round counter out of range");
   a_last_wrap: assert property (@(posedge clock) disable iff (reset)
      stat.round_last |=> cnt_ff == '0)
      else $error("round counter did not wrap after the last round");
`endif

endmodule

// File: hw/rtl/sha1_stream_hash.sv
// SHA-1 over a byte stream. A data transaction shifts one byte into the block; the byte that
// completes a 64-byte block starts 80 rounds and then the chain add, through one round unit.
// A finish transaction pads one byte per cycle up to the length field, runs one or two
// compressions, then presents five digest words, one per accepted transaction.
// Requests are not taken while a block is compressed. Synchronous reset loads the initial
// chain words and clears byte and bit counts; the block buffer needs no clearing.
module sha1_stream_hash (
   input  logic        clock,
   input  logic        reset,
   sha1_req_if.sink    req_ch,
   sha1_rsp_if.source  rsp_ch
);
   import sha1_pkg::*;

   state_type          state_ff, state_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [63:0]        bits_ff, bits_in;
   logic               fin_ff, fin_in;
   logic               done_ff, done_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;

   eng_ctrl_type ctrl;
   eng_stat_type stat;
   logic         req_ready;
   logic         rsp_valid;
   logic         req_take;
   logic         rsp_take;
   logic         fill_full;
   logic         idx_last;

   assign req_take  = req_ch.valid && req_ready;
   assign rsp_take  = rsp_valid && rsp_ch.ready;
   assign fill_full = (fill_ff == FILL_W'(BLOCK_BYTES - 1));
   assign idx_last  = (idx_ff == IDX_W'(DIGEST_WORDS - 1));

   sha1_engine u_engine (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .stat  (stat)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (fill_full) begin
                  state_in = ST_ROUND;
               end else if (req_ch.kind == KIND_FINISH) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (fill_ff == FILL_W'(LEN_FILL)) begin
               state_in = ST_LEN;
            end else if (fill_full) begin
               state_in = ST_ROUND;
            end
         end
         ST_LEN: begin
            if (fill_full) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (stat.round_last) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (done_ff) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_EMIT: begin
            if (rsp_take && idx_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl      = '0;
      fill_in   = fill_ff;
      bits_in   = bits_ff;
      fin_in    = fin_ff;
      done_in   = done_ff;
      idx_in    = idx_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_take) begin
               ctrl.shift_byte = 1'b1;
               ctrl.load       = fill_full;
               fill_in         = fill_ff + FILL_W'(1);
               if (req_ch.kind == KIND_FINISH) begin
                  ctrl.byte_val = PAD_BYTE;
                  fin_in        = 1'b1;
                  // freeze the message length before padding starts
                  bits_in       = bits_ff + 64'({fill_ff, 3'b000});
               end else begin
                  ctrl.byte_val = req_ch.msg_byte;
                  if (fill_full) begin
                     bits_in = bits_ff + 64'(BLOCK_BITS);
                  end
               end
            end
         end
         ST_PAD: begin
            if (fill_ff != FILL_W'(LEN_FILL)) begin
               ctrl.shift_byte = 1'b1;
               ctrl.byte_val   = '0;
               ctrl.load       = fill_full;
               fill_in         = fill_ff + FILL_W'(1);
            end
         end
         ST_LEN: begin
            // shift out the length, most significant byte first
            ctrl.shift_byte = 1'b1;
            ctrl.byte_val   = bits_ff[63:56];
            ctrl.load       = fill_full;
            bits_in         = {bits_ff[55:0], 8'h00};
            fill_in         = fill_ff + FILL_W'(1);
            if (fill_full) begin
               done_in = 1'b1;
            end
         end
         ST_ROUND: begin
            ctrl.round = 1'b1;
         end
         ST_ADD: begin
            ctrl.add = 1'b1;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_take) begin
               ctrl.rotate = 1'b1;
               idx_in      = idx_ff + IDX_W'(1);
               if (idx_last) begin
                  ctrl.init = 1'b1;
                  idx_in    = '0;
                  fin_in    = 1'b0;
                  done_in   = 1'b0;
                  bits_in   = '0;
               end
            end
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         bits_ff  <= '0;
         fin_ff   <= 1'b0;
         done_ff  <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         fin_ff   <= fin_in;
         done_ff  <= done_in;
         idx_ff   <= idx_in;
      end
   end

   assign req_ch.ready       = req_ready;
   assign rsp_ch.valid       = rsp_valid;
   assign rsp_ch.digest_word = stat.h0;
   assign rsp_ch.word_index  = idx_ff;
   assign rsp_ch.last_word   = idx_last;

`ifndef SYNTHESIS
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and response sides active together");
   a_clean_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && idx_last) |=> (fill_ff == '0) && (bits_ff == '0) && !fin_ff)
      else $error("state not re-initialized after the last digest word");
   a_len_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEN) |-> (fill_ff >= FILL_W'(LEN_FILL)))
      else $error("length field started at the wrong byte position");
   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (fin_ff && done_ff && (fill_ff == '0)))
      else $error("digest presented before the final block");
`endif

endmodule

// File: tb/tb_sha1_stream_hash.sv
// Self-checking bench for sha1_stream_hash: byte streams and finish transactions are
// driven in, digest words are checked against a SHA-1 model kept in the bench.
// Depends on sha1_pkg and the sha1_req_if / sha1_rsp_if channel interfaces.
module tb_sha1_stream_hash;
   timeunit 1ns;
   timeprecision 1ps;

   import sha1_pkg::*;

   localparam int RANDOM_ITEMS = 330;
   localparam int STALL_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 300;

   typedef struct {
      logic       kind;
      logic [7:0] msg_byte;
   } hash_item_type;

   typedef struct {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_word_type;

   logic clock;
   logic reset;

   sha1_req_if req_if ();
   sha1_rsp_if rsp_if ();

   sha1_stream_hash dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   hash_item_type   pending_items[$];
   hash_item_type   cur_item;
   digest_word_type digest_expect[$];

   // bench copy of the hash state
   logic [31:0] hash_chain [DIGEST_WORDS];
   logic [7:0]  blk_bytes [BLOCK_BYTES];
   int          blk_fill;
   logic [63:0] done_bits;

   int total_items;
   int items_taken;
   int words_checked;
   int msg_count;
   int byte_count;
   int err_count;
   int stall_cycles;
   int hold_left;
   bit pressure_done;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic void hash_init();
      hash_chain[0] = H_INIT0;
      hash_chain[1] = H_INIT1;
      hash_chain[2] = H_INIT2;
      hash_chain[3] = H_INIT3;
      hash_chain[4] = H_INIT4;
      blk_fill      = 0;
      done_bits     = '0;
   endfunction

   function automatic void compress_block();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int r = 0; r < 16; r++)
         w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
      for (int r = 16; r < 80; r++)
         w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
      a = hash_chain[0];
      b = hash_chain[1];
      c = hash_chain[2];
      d = hash_chain[3];
      e = hash_chain[4];
      for (int r = 0; r < 80; r++) begin
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = K_ROUND0;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = K_ROUND1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_ROUND2;
         end else begin
            f = b ^ c ^ d;
            k = K_ROUND3;
         end
         t = rotl(a, 5) + f + e + k + w[r];
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t;
      end
      hash_chain[0] += a;
      hash_chain[1] += b;
      hash_chain[2] += c;
      hash_chain[3] += d;
      hash_chain[4] += e;
   endfunction

   // absorb one accepted transaction; a finish queues the five digest words
   function automatic void sha1_absorb(input hash_item_type item);
      int              pos;
      logic [63:0]     msg_len;
      digest_word_type dw;
      if (item.kind == KIND_DATA) begin
         blk_bytes[blk_fill] = item.msg_byte;
         blk_fill = (blk_fill + 1) % BLOCK_BYTES;
         if (blk_fill == 0) begin
            compress_block();
            done_bits += 64'(BLOCK_BITS);
         end
         return;
      end
      pos = blk_fill;
      msg_len = done_bits + 64'(pos) * 64'd8;
      blk_bytes[pos] = PAD_BYTE;
      pos = pos + 1;
      // no room left for the length field: flush one extra block
      if (pos > LEN_FILL) begin
         while (pos < BLOCK_BYTES) begin
            blk_bytes[pos] = 8'h00;
            pos = pos + 1;
         end
         compress_block();
         pos = 0;
      end
      while (pos < LEN_FILL) begin
         blk_bytes[pos] = 8'h00;
         pos = pos + 1;
      end
      for (int j = 0; j < 8; j++)
         blk_bytes[BLOCK_BYTES - 1 - j] = msg_len[8*j +: 8];
      compress_block();
      for (int j = 0; j < DIGEST_WORDS; j++) begin
         dw.digest_word = hash_chain[j];
         dw.word_index  = 3'(j);
         dw.last_word   = (j == DIGEST_WORDS - 1);
         digest_expect.push_back(dw);
      end
      hash_init();
   endfunction

   function automatic void queue_message(input int len);
      hash_item_type item;
      for (int i = 0; i < len; i++) begin
         item.kind     = KIND_DATA;
         item.msg_byte = 8'($urandom_range(0, 255));
         pending_items.push_back(item);
      end
      item.kind     = KIND_FINISH;
      item.msg_byte = 8'($urandom_range(0, 255));
      pending_items.push_back(item);
      msg_count  += 1;
      byte_count += len;
   endfunction

   function automatic void queue_bytes(input logic [7:0] bytes[$]);
      hash_item_type item;
      foreach (bytes[i]) begin
         item.kind     = KIND_DATA;
         item.msg_byte = bytes[i];
         pending_items.push_back(item);
      end
      item.kind     = KIND_FINISH;
      item.msg_byte = 8'hff;
      pending_items.push_back(item);
      msg_count  += 1;
      byte_count += bytes.size();
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // driver: present queued transactions, advance on acceptance
   always @(posedge clock) begin
      bit idle_tx;
      if (reset) begin
         req_if.valid    <= 1'b0;
         req_if.kind     <= KIND_DATA;
         req_if.msg_byte <= 8'h00;
      end else begin
         if (req_if.valid && req_if.ready) begin
            sha1_absorb(cur_item);
            items_taken += 1;
         end
         if (!req_if.valid || req_if.ready) begin
            idle_tx = !(items_taken >= 120 && items_taken < 220) &&
                      ($urandom_range(0, 99) < 8);
            if (pending_items.size() != 0 && !idle_tx) begin
               cur_item = pending_items.pop_front();
               req_if.valid    <= 1'b1;
               req_if.kind     <= cur_item.kind;
               req_if.msg_byte <= cur_item.msg_byte;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check digest words in order, drive ready with stalls and one long hold-off
   always @(posedge clock) begin
      digest_word_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (digest_expect.size() == 0) begin
               $error("unexpected digest word %h index %0d",
                      rsp_if.digest_word, rsp_if.word_index);
               err_count += 1;
            end else begin
               want = digest_expect.pop_front();
               if (rsp_if.digest_word !== want.digest_word) begin
                  $error("digest_word mismatch: expected %h, actual %h",
                         want.digest_word, rsp_if.digest_word);
                  err_count += 1;
               end
               if (rsp_if.word_index !== want.word_index) begin
                  $error("word_index mismatch: expected %0d, actual %0d",
                         want.word_index, rsp_if.word_index);
                  err_count += 1;
               end
               if (rsp_if.last_word !== want.last_word) begin
                  $error("last_word mismatch: expected %0b, actual %0b",
                         want.last_word, rsp_if.last_word);
                  err_count += 1;
               end
            end
            words_checked += 1;
         end
         // hold off once a third digest shows up, so the input backs up
         if (!pressure_done && rsp_if.valid && words_checked >= 10) begin
            pressure_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left -= 1;
            rsp_if.ready <= 1'b0;
         end else if (words_checked >= 25 && words_checked < 50) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= 8);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles += 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      int          rnd_start;
      int          len;
      logic [7:0]  msg[$];
      int          edge_lens[$];
      req_if.valid    = 1'b0;
      req_if.kind     = KIND_DATA;
      req_if.msg_byte = 8'h00;
      rsp_if.ready    = 1'b0;
      reset           = 1'b1;
      items_taken     = 0;
      words_checked   = 0;
      msg_count       = 0;
      byte_count      = 0;
      err_count       = 0;
      stall_cycles    = 0;
      hold_left       = 0;
      pressure_done   = 1'b0;
      for (int i = 0; i < BLOCK_BYTES; i++)
         blk_bytes[i] = 8'h00;
      hash_init();

      // directed: empty message twice, "abc", byte extremes, lone pad-valued byte
      msg = {};
      queue_bytes(msg);
      queue_bytes(msg);
      msg = {8'h61, 8'h62, 8'h63};
      queue_bytes(msg);
      msg = {8'h00, 8'hff};
      queue_bytes(msg);
      msg = {8'h80};
      queue_bytes(msg);

      // random messages, with block and padding boundaries weighted in
      edge_lens = {55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
      rnd_start = pending_items.size();
      while (pending_items.size() - rnd_start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 3)
            len = edge_lens[$urandom_range(0, edge_lens.size() - 1)];
         else
            len = $urandom_range(0, 40);
         // trim the last message so the random part ends on the item budget
         if (len > RANDOM_ITEMS - (pending_items.size() - rnd_start) - 1)
            len = RANDOM_ITEMS - (pending_items.size() - rnd_start) - 1;
         queue_message(len);
      end
      total_items = pending_items.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (items_taken != total_items || digest_expect.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Hashed %0d messages (%0d bytes, %0d transactions), %0d digest words checked",
               msg_count, byte_count, total_items, words_checked);
      $display("Covered empty messages, block and padding boundaries, and a long output stall");
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
